[sv/bfor_pkg.sv]
// ----------------------------------------------------------------------------
// bfor_pkg
// Shared constants and types for the byte first-occurrence relabeling block.
// ----------------------------------------------------------------------------
package bfor_pkg;

    localparam int DATA_W          = 8;
    localparam int LABEL_W         = 8;
    localparam int COUNT_W         = 9;
    localparam int ALPHABET_SIZE_D = 256;

    // Result of one relabeling step, handed from the core to the output stage.
    typedef struct packed {
        logic               is_new;
        logic [LABEL_W-1:0] label;
        logic [COUNT_W-1:0] count;
    } t_upd;

    // Write request into the label memory.
    typedef struct packed {
        logic               en;
        logic [DATA_W-1:0]  addr;
        logic [LABEL_W-1:0] data;
    } t_wr_req;

endpackage

[sv/bfor_in_if.sv]
// ----------------------------------------------------------------------------
// bfor_in_if
// Input channel: one raw byte per transfer with an end-of-block flag.
// ----------------------------------------------------------------------------
interface bfor_in_if;
    logic                        valid;
    logic                        ready;
    logic [bfor_pkg::DATA_W-1:0] data_byte;
    logic                        end_of_block;

    modport source (output valid, output data_byte, output end_of_block, input ready);
    modport sink   (input valid, input data_byte, input end_of_block, output ready);
endinterface

[sv/bfor_out_if.sv]
// ----------------------------------------------------------------------------
// bfor_out_if
// Output channel: one label per transfer with the running distinct count.
// ----------------------------------------------------------------------------
interface bfor_out_if;
    logic                         valid;
    logic                         ready;
    logic [bfor_pkg::LABEL_W-1:0] symbol_label;
    logic                         end_flag;
    logic [bfor_pkg::COUNT_W-1:0] distinct_count;

    modport source (output valid, output symbol_label, output end_flag,
                    output distinct_count, input ready);
    modport sink   (input valid, input symbol_label, input end_flag,
                    input distinct_count, output ready);
endinterface

[sv/bfor_label_mem.sv]
// ----------------------------------------------------------------------------
// bfor_label_mem
// Label table: one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfor_label_mem #(
    parameter int ALPHABET_SIZE = bfor_pkg::ALPHABET_SIZE_D,
    parameter int AW            = $clog2(ALPHABET_SIZE)
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [bfor_pkg::LABEL_W-1:0] i_wr_data,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [bfor_pkg::LABEL_W-1:0] o_rd_data
);
    import bfor_pkg::*;

    logic [LABEL_W-1:0] r_mem [ALPHABET_SIZE];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read-before-write: a read that hits the entry being written returns old data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[sv/bfor_core.sv]
// ----------------------------------------------------------------------------
// bfor_core
// Seen flags, label counter and the read-modify-write decision per byte.
// ----------------------------------------------------------------------------
module bfor_core #(
    parameter int ALPHABET_SIZE = bfor_pkg::ALPHABET_SIZE_D,
    parameter int AW            = $clog2(ALPHABET_SIZE)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [AW-1:0]                i_addr,
    input  logic                         i_last,
    input  logic [bfor_pkg::LABEL_W-1:0] i_mem_q,
    input  logic                         i_fwd_hit,
    input  logic [bfor_pkg::LABEL_W-1:0] i_fwd_data,
    output bfor_pkg::t_upd               o_upd,
    output bfor_pkg::t_wr_req            o_wr
);
    import bfor_pkg::*;

    logic [ALPHABET_SIZE-1:0] r_seen;
    logic [ALPHABET_SIZE-1:0] n_seen;
    logic [COUNT_W-1:0]       r_next_label;
    logic [COUNT_W-1:0]       n_next_label;
    logic [COUNT_W-1:0]       count_after;
    logic                     is_new;
    logic [LABEL_W-1:0]       old_label;

    always_comb begin
        is_new    = !r_seen[i_addr];
        // A write in the cycle the entry was read is not in the memory output yet.
        old_label = i_fwd_hit ? i_fwd_data : i_mem_q;
        if (is_new && (r_next_label < COUNT_W'(ALPHABET_SIZE))) begin
            count_after = r_next_label + COUNT_W'(1);
        end else begin
            count_after = r_next_label;
        end

        o_upd.is_new = is_new;
        o_upd.label  = is_new ? r_next_label[LABEL_W-1:0] : old_label;
        o_upd.count  = count_after;

        o_wr.en   = i_fire && is_new;
        o_wr.addr = DATA_W'(i_addr);
        o_wr.data = r_next_label[LABEL_W-1:0];

        n_seen       = r_seen;
        n_next_label = r_next_label;
        if (i_fire) begin
            if (i_last) begin
                n_seen       = '0;
                n_next_label = '0;
            end else begin
                n_seen[i_addr] = 1'b1;
                n_next_label   = count_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= '0;
            r_next_label <= '0;
        end else begin
            r_seen       <= n_seen;
            r_next_label <= n_next_label;
        end
    end

endmodule

[sv/byte_first_occurrence_relabel.sv]
// ----------------------------------------------------------------------------
// byte_first_occurrence_relabel
// Replaces each byte of a block by the order in which its value first appeared.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the output side is not stalled and
// returns one label per byte through stage one and the output register. The
// label memory sets that rate: each byte costs one read, issued at the input
// transfer, and at most one write, made as the byte leaves stage one. A byte
// whose value was entered into the table by the byte just ahead of it gets the
// label through a forwarding register. Seen flags are flip-flops that reset and
// the end of each block clear at once, so no clearing pass is needed and the
// next block may start in the cycle after the last byte of the previous one.
// ----------------------------------------------------------------------------
module byte_first_occurrence_relabel #(
    parameter int ALPHABET_SIZE = bfor_pkg::ALPHABET_SIZE_D
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfor_in_if.sink    i_in,
    bfor_out_if.source o_out
);
    import bfor_pkg::*;

    localparam int AW = $clog2(ALPHABET_SIZE);

    // Byte values beyond the alphabet fold onto its top entry.
    logic [AW-1:0]      in_addr;
    logic               in_fire;
    logic               s1_fire;

    // Stage one holds the byte whose table read is in flight.
    logic               r_s1_valid;
    logic [AW-1:0]      r_s1_addr;
    logic               r_s1_last;
    logic               r_fwd_hit;
    logic [LABEL_W-1:0] r_fwd_data;

    // Output register parts the output handshake from the table update.
    logic               r_out_valid;
    logic [LABEL_W-1:0] r_out_label;
    logic               r_out_last;
    logic [COUNT_W-1:0] r_out_count;

    logic [LABEL_W-1:0] mem_q;
    t_upd               upd;
    t_wr_req            wr;

    always_comb begin
        if ({1'b0, i_in.data_byte} >= (DATA_W+1)'(ALPHABET_SIZE)) begin
            in_addr = AW'(ALPHABET_SIZE - 1);
        end else begin
            in_addr = i_in.data_byte[AW-1:0];
        end
    end

    assign s1_fire    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // The read issued now misses a write made to the same entry in this cycle,
    // so that write is captured alongside the byte.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_addr  <= in_addr;
            r_s1_last  <= i_in.end_of_block;
            r_fwd_hit  <= wr.en && (wr.addr[AW-1:0] == in_addr);
            r_fwd_data <= wr.data;
        end
    end

    bfor_label_mem #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .AW            (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr.addr[AW-1:0]),
        .i_wr_data (wr.data),
        .i_rd_en   (in_fire),
        .i_rd_addr (in_addr),
        .o_rd_data (mem_q)
    );

    bfor_core #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .AW            (AW)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (s1_fire),
        .i_addr     (r_s1_addr),
        .i_last     (r_s1_last),
        .i_mem_q    (mem_q),
        .i_fwd_hit  (r_fwd_hit),
        .i_fwd_data (r_fwd_data),
        .o_upd      (upd),
        .o_wr       (wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_label <= upd.label;
            r_out_last  <= r_s1_last;
            r_out_count <= upd.count;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.symbol_label   = r_out_label;
    assign o_out.end_flag       = r_out_last;
    assign o_out.distinct_count = r_out_count;

    // Every delivered byte has been counted, and its label is below the count.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count != '0))
        else $error("distinct count is zero on a delivered result");

    a_label_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ({1'b0, r_out_label} < r_out_count))
        else $error("label not below distinct count");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count <= COUNT_W'(ALPHABET_SIZE)))
        else $error("distinct count beyond alphabet size");

    // A new value always gets the next label, which equals the old count.
    a_new_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && upd.is_new) |=> (COUNT_W'(r_out_label) == r_out_count - COUNT_W'(1))
            || (r_out_count == COUNT_W'(ALPHABET_SIZE)))
        else $error("new value did not take the next label");

    // A stalled byte in stage one blocks the input.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |-> !i_in.ready)
        else $error("input accepted while stage one is stalled");

endmodule

[bench/bfor_relabel_checker.sv]
// ----------------------------------------------------------------------------
// bfor_relabel_checker
// Watches both channels of the relabeling block and checks every result.
// ----------------------------------------------------------------------------
// Each byte accepted on the input channel is relabeled here by a local copy of
// the first-occurrence table. The expected result is queued. Each result
// accepted on the output channel is compared field by field with the oldest
// queued entry. Counters go back to the top for the end-of-run decision.
// ----------------------------------------------------------------------------
module bfor_relabel_checker #(
    parameter int ALPHABET_SIZE = bfor_pkg::ALPHABET_SIZE_D
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bfor_in_if   i_in_mon,
    bfor_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_result_count,
    output int   o_block_count,
    output int   o_peak_distinct
);
    import bfor_pkg::*;

    typedef struct packed {
        logic [LABEL_W-1:0] symbol_label;
        logic               end_flag;
        logic [COUNT_W-1:0] distinct_count;
    } label_result_t;

    // Local copy of the relabeling state.
    bit                 seen_map  [256];
    logic [LABEL_W-1:0] label_map [256];
    logic [COUNT_W-1:0] first_free;

    label_result_t expected_labels [$];
    label_result_t want;
    int            mismatches = 0;
    int            results    = 0;
    int            blocks     = 0;
    int            peak       = 0;

    // Relabels one byte and advances the table. Bytes past the alphabet are
    // folded onto its top symbol. The end of a block clears the table after
    // the result has been formed.
    function automatic label_result_t relabel_byte(input logic [DATA_W-1:0] raw,
                                                   input logic last);
        int            sym;
        label_result_t r;
        sym = (int'(raw) >= ALPHABET_SIZE) ? ALPHABET_SIZE - 1 : int'(raw);
        if (!seen_map[sym]) begin
            seen_map[sym]  = 1'b1;
            label_map[sym] = first_free[LABEL_W-1:0];
            if (first_free < ALPHABET_SIZE)
                first_free = first_free + COUNT_W'(1);
        end
        r.symbol_label   = label_map[sym];
        r.end_flag       = last;
        r.distinct_count = first_free;
        if (last) begin
            seen_map   = '{default: 1'b0};
            first_free = '0;
        end
        return r;
    endfunction

    // Adds an expected result at the tail of the pending queue.
    task automatic queue_expected(input label_result_t e);
        expected_labels.insert(expected_labels.size(), e);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seen_map   = '{default: 1'b0};
            first_free = '0;
            expected_labels.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                queue_expected(relabel_byte(i_in_mon.data_byte,
                                            i_in_mon.end_of_block));
            if (i_out_mon.valid && i_out_mon.ready) begin
                results++;
                if (i_out_mon.end_flag === 1'b1)
                    blocks++;
                if (int'(i_out_mon.distinct_count) > peak)
                    peak = int'(i_out_mon.distinct_count);
                if (expected_labels.size() == 0) begin
                    $error("result with no byte pending: symbol_label %0d end_flag %0d",
                           i_out_mon.symbol_label, i_out_mon.end_flag);
                    mismatches++;
                end else begin
                    want = expected_labels.pop_front();
                    if (i_out_mon.symbol_label !== want.symbol_label) begin
                        $error("symbol_label: expected %0d, actual %0d",
                               want.symbol_label, i_out_mon.symbol_label);
                        mismatches++;
                    end
                    if (i_out_mon.end_flag !== want.end_flag) begin
                        $error("end_flag: expected %0d, actual %0d",
                               want.end_flag, i_out_mon.end_flag);
                        mismatches++;
                    end
                    if (i_out_mon.distinct_count !== want.distinct_count) begin
                        $error("distinct_count: expected %0d, actual %0d",
                               want.distinct_count, i_out_mon.distinct_count);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count    <= mismatches;
        o_outstanding   <= expected_labels.size();
        o_result_count  <= results;
        o_block_count   <= blocks;
        o_peak_distinct <= peak;
    end

endmodule

[bench/tb_byte_first_occurrence_relabel.sv]
// ----------------------------------------------------------------------------
// tb_byte_first_occurrence_relabel
// Stimulus and verdict for the byte first-occurrence relabeling block.
// ----------------------------------------------------------------------------
// A short directed run covers single-byte blocks, the byte extremes, repeated
// values and a block right after another one. Random blocks follow: small
// pools with many repeats, uniform bytes, and two blocks that use all 256
// byte values. Both channels are paced with random gaps. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_byte_first_occurrence_relabel;
    import bfor_pkg::*;

    localparam int ALPHABET = ALPHABET_SIZE_D;
    localparam int BYTE_GOAL = 1350;

    logic i_clk;
    logic i_rst_n;

    bfor_in_if  in_ch ();
    bfor_out_if out_ch ();

    int fail_count;
    int outstanding;
    int result_count;
    int block_count;
    int peak_distinct;

    // Bytes of the block that is about to be sent, and pacing state.
    logic [DATA_W-1:0] blk_bytes [$];
    int                bytes_sent;
    bit                source_calm;
    bit                sink_calm;

    byte_first_occurrence_relabel #(
        .ALPHABET_SIZE(ALPHABET)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    bfor_relabel_checker #(
        .ALPHABET_SIZE(ALPHABET)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_result_count  (result_count),
        .o_block_count   (block_count),
        .o_peak_distinct (peak_distinct)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Length of an idle gap. Most gaps are short and a few are long; in a
    // calm stretch there are none at all.
    function automatic int idle_len(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Adds one byte at the end of the block being built.
    task automatic append_byte(input logic [DATA_W-1:0] b);
        blk_bytes.insert(blk_bytes.size(), b);
    endtask

    // Sends the bytes in blk_bytes as one block, with the end flag on the last.
    // Every transfer is followed by an optional gap. While valid is low the
    // payload carries random noise, which the block must ignore. When there is
    // no gap, valid simply stays high and the next byte is driven in the same
    // step as the transfer of the previous one.
    task automatic send_block();
        int gap;
        foreach (blk_bytes[k]) begin
            gap = idle_len(source_calm);
            if (gap > 0) begin
                in_ch.valid        <= 1'b0;
                in_ch.data_byte    <= DATA_W'($urandom);
                in_ch.end_of_block <= 1'($urandom);
                repeat (gap) @(posedge i_clk);
            end
            in_ch.valid        <= 1'b1;
            in_ch.data_byte    <= blk_bytes[k];
            in_ch.end_of_block <= (k == blk_bytes.size() - 1);
            @(posedge i_clk);
            while (!in_ch.ready)
                @(posedge i_clk);
            bytes_sent++;
        end
    endtask

    // Output side pacing: runs of ready high broken by stalls. Now and then
    // the pacing switches into or out of a calm stretch with no stalls.
    initial begin : sink_pacing
        int n;
        sink_calm = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            out_ch.ready <= 1'b1;
            n = $urandom_range(1, 40);
            repeat (n) @(posedge i_clk);
            if ($urandom_range(0, 9) == 0)
                sink_calm = !sink_calm;
            n = idle_len(sink_calm);
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [DATA_W-1:0] pool  [8];
        logic [DATA_W-1:0] perm  [256];
        logic [DATA_W-1:0] tmp;
        int                blk_no;
        int                len;
        int                pool_n;
        int                extra;
        int                j;

        bytes_sent  = 0;
        source_calm = 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= '0;
        in_ch.end_of_block <= 1'b0;
        i_rst_n            <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-byte blocks at both ends of the byte range: label 0, count 1.
        blk_bytes = {8'h00};
        send_block();
        blk_bytes = {8'hFF};
        send_block();
        // Extremes, alternating bit patterns and repeats of earlier values.
        blk_bytes = {8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h80, 8'h55, 8'hAA};
        send_block();
        // One value over and over, including back-to-back repeats right after
        // the value was first entered.
        blk_bytes = {8'h5A, 8'h5A, 8'h5A, 8'h5A};
        send_block();
        // The same values again in a fresh block: labels must restart at 0.
        blk_bytes = {8'hFF, 8'h00};
        send_block();

        blk_no = 0;
        while (bytes_sent < BYTE_GOAL) begin
            source_calm = ($urandom_range(0, 3) == 0);
            blk_bytes.delete();
            if (blk_no == 3 || blk_no == 40) begin
                // Every byte value once in shuffled order, so the count reaches
                // its top. The first such block ends exactly on the 256th new
                // value; the second adds a few repeats after it.
                for (int i = 0; i < 256; i++)
                    perm[i] = DATA_W'(i);
                for (int i = 255; i > 0; i--) begin
                    j       = $urandom_range(0, i);
                    tmp     = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                for (int i = 0; i < 256; i++)
                    append_byte(perm[i]);
                extra = (blk_no == 3) ? 0 : $urandom_range(1, 20);
                for (int i = 0; i < extra; i++)
                    append_byte(DATA_W'($urandom));
            end else if ($urandom_range(0, 1) == 0) begin
                // A few values repeated many times.
                pool_n = $urandom_range(1, 8);
                for (int i = 0; i < pool_n; i++)
                    pool[i] = DATA_W'($urandom);
                len = $urandom_range(1, 24);
                for (int i = 0; i < len; i++)
                    append_byte(pool[$urandom_range(0, pool_n - 1)]);
            end else begin
                len = $urandom_range(1, 40);
                for (int i = 0; i < len; i++)
                    append_byte(DATA_W'($urandom));
            end
            send_block();
            blk_no++;
        end
        in_ch.valid <= 1'b0;

        // The checker's count of pending results is registered, so let it see the last
        // transfer before waiting for the queue to drain.
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Relabeled %0d bytes in %0d blocks; the largest block held %0d distinct values.",
                 result_count, block_count, peak_distinct);
        $display("Both channels ran with random gaps and stalls, including stretches with none.");
        if (fail_count == 0) begin
            $display("tb_byte_first_occurrence_relabel passed");
        end else begin
            $display("tb_byte_first_occurrence_relabel failed");
        end
        $finish;
    end

    // Guard against a hung handshake. This is far beyond the slowest correct run.
    initial begin : watchdog
        #4000000;
        $display("tb_byte_first_occurrence_relabel failed");
        $finish;
    end

endmodule
